// File: hw/rtl/calendar_date_offset_macros.svh
// ----------------------------------------------------------------------------
// calendar_date_offset_macros.svh
// Assertion macros for the calendar date offset RTL.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_OFFSET_MACROS_SVH
`define CALENDAR_DATE_OFFSET_MACROS_SVH

// Same-cycle implication
`define CDO_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CDO_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/cdo_pkg.sv
// ----------------------------------------------------------------------------
// cdo_pkg
// Types, constants and the month-length function of the date offset block.
// ----------------------------------------------------------------------------
package cdo_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int OFF_W   = 21;
  localparam int STAT_W  = 2;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;

  localparam logic [YEAR_W-1:0]  YEAR_MIN    = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
  localparam logic [YEAR_W-1:0]  LEAP_CYCLE  = 14'd400;
  localparam logic [YEAR_W-1:0]  CENTURY     = 14'd100;
  localparam logic [MONTH_W-1:0] MONTHS      = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
  localparam logic [DAY_W-1:0]   LEAP_FEB    = 5'd29;
  localparam logic [DAY_W-1:0]   DEC_LEN     = 5'd31;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_SAT     = 2'd2
  } status_t;

  typedef struct packed {
    logic load;
    logic reduce;
    logic mark_bad;
    logic step;
    logic sat;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic ge_cycle;
    logic date_ok;
    logic cnt_zero;
    logic at_end;
    logic out_free;
  } sts_t;

  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                               input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MONTH_FEB: len = leap ? LEAP_FEB : 5'd28;
      default:   len = '0;
    endcase
    return len;
  endfunction

endpackage

// File: hw/rtl/cdo_datapath.sv
// ----------------------------------------------------------------------------
// cdo_datapath
// Date registers, year-mod-400 tracker, day counter and output register.
// ----------------------------------------------------------------------------
module cdo_datapath #(
  parameter int OFFSET_LIMIT = 1048575
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cdo_pkg::cmd_t                    cmd,
  output cdo_pkg::sts_t                    sts,
  input  logic [cdo_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [cdo_pkg::OUT_DATA_W-1:0]   out_tdata
);

  localparam int OffW     = cdo_pkg::OFF_W;
  localparam int MagMax   = 1 << (OffW - 1);
  localparam int EffLimit = (OFFSET_LIMIT > MagMax) ? MagMax : OFFSET_LIMIT;
  localparam logic [OffW-1:0] Limit = OffW'(EffLimit);

  localparam int YW = cdo_pkg::YEAR_W;
  localparam int MW = cdo_pkg::MONTH_W;
  localparam int DW = cdo_pkg::DAY_W;
  localparam int SW = cdo_pkg::STAT_W;

  logic [YW-1:0]   yr_r, yr_nxt;
  logic [MW-1:0]   mo_r, mo_nxt;
  logic [DW-1:0]   dy_r, dy_nxt;
  logic [YW-1:0]   ym_r, ym_nxt;
  logic            back_r, back_nxt;
  logic [OffW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0]   st_r, st_nxt;
  logic            ov_r, ov_nxt;
  logic [cdo_pkg::OUT_DATA_W-1:0] od_r, od_nxt;

  logic [OffW-1:0] off_in, mag, clamped;
  logic            leap, at_lo, at_hi;
  logic [MW-1:0]   mo_prev;
  logic [DW-1:0]   dim_cur, dim_prev;
  logic [YW-1:0]   ym_inc, ym_dec;

  assign off_in  = in_tdata[43:23];
  assign mag     = off_in[OffW-1] ? (~off_in + OffW'(1)) : off_in;
  assign clamped = (mag > Limit) ? Limit : mag;

  assign leap = ((ym_r[1:0] == 2'b00) && (ym_r != '0) && (ym_r != cdo_pkg::CENTURY)
                 && (ym_r != YW'(2 * cdo_pkg::CENTURY))
                 && (ym_r != YW'(3 * cdo_pkg::CENTURY)))
                || (ym_r == '0);

  assign mo_prev  = (mo_r == MW'(1)) ? cdo_pkg::MONTHS : (mo_r - MW'(1));
  assign dim_cur  = cdo_pkg::days_in(mo_r, leap);
  assign dim_prev = cdo_pkg::days_in(mo_prev, leap);

  assign ym_inc = (ym_r == cdo_pkg::LEAP_CYCLE - YW'(1)) ? '0 : (ym_r + YW'(1));
  assign ym_dec = (ym_r == '0) ? (cdo_pkg::LEAP_CYCLE - YW'(1)) : (ym_r - YW'(1));

  assign at_lo = (yr_r == cdo_pkg::YEAR_MIN) && (mo_r == MW'(1)) && (dy_r == DW'(1));
  assign at_hi = (yr_r == cdo_pkg::YEAR_MAX) && (mo_r == cdo_pkg::MONTHS)
                 && (dy_r == cdo_pkg::DEC_LEN);

  always_comb begin
    sts.ge_cycle = (ym_r >= cdo_pkg::LEAP_CYCLE);
    sts.date_ok  = (yr_r >= cdo_pkg::YEAR_MIN) && (yr_r <= cdo_pkg::YEAR_MAX)
                   && (mo_r != '0) && (mo_r <= cdo_pkg::MONTHS)
                   && (dy_r != '0) && (dy_r <= dim_cur);
    sts.cnt_zero = (cnt_r == '0);
    sts.at_end   = back_r ? at_lo : at_hi;
    sts.out_free = !ov_r || out_tready;
  end

  always_comb begin
    yr_nxt   = yr_r;
    mo_nxt   = mo_r;
    dy_nxt   = dy_r;
    ym_nxt   = ym_r;
    back_nxt = back_r;
    cnt_nxt  = cnt_r;
    st_nxt   = st_r;
    ov_nxt   = ov_r && !out_tready;
    od_nxt   = od_r;
    if (cmd.load) begin
      yr_nxt   = in_tdata[13:0];
      mo_nxt   = in_tdata[17:14];
      dy_nxt   = in_tdata[22:18];
      ym_nxt   = in_tdata[13:0];
      back_nxt = off_in[OffW-1];
      cnt_nxt  = clamped;
      st_nxt   = cdo_pkg::ST_OK;
    end
    if (cmd.reduce) begin
      ym_nxt = ym_r - cdo_pkg::LEAP_CYCLE;
    end
    if (cmd.mark_bad) begin
      st_nxt = cdo_pkg::ST_INVALID;
    end
    if (cmd.sat) begin
      st_nxt = cdo_pkg::ST_SAT;
    end
    if (cmd.step) begin
      cnt_nxt = cnt_r - OffW'(1);
      if (!back_r) begin
        if (dy_r < dim_cur) begin
          dy_nxt = dy_r + DW'(1);
        end else begin
          dy_nxt = DW'(1);
          if (mo_r < cdo_pkg::MONTHS) begin
            mo_nxt = mo_r + MW'(1);
          end else begin
            mo_nxt = MW'(1);
            yr_nxt = yr_r + YW'(1);
            ym_nxt = ym_inc;
          end
        end
      end else begin
        if (dy_r > DW'(1)) begin
          dy_nxt = dy_r - DW'(1);
        end else if (mo_r > MW'(1)) begin
          mo_nxt = mo_prev;
          dy_nxt = dim_prev;
        end else begin
          mo_nxt = cdo_pkg::MONTHS;
          dy_nxt = cdo_pkg::DEC_LEN;
          yr_nxt = yr_r - YW'(1);
          ym_nxt = ym_dec;
        end
      end
    end
    if (cmd.emit) begin
      ov_nxt = 1'b1;
      od_nxt = {7'd0, st_r, dy_r, mo_r, yr_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
    yr_r   <= yr_nxt;
    mo_r   <= mo_nxt;
    dy_r   <= dy_nxt;
    ym_r   <= ym_nxt;
    back_r <= back_nxt;
    cnt_r  <= cnt_nxt;
    st_r   <= st_nxt;
    od_r   <= od_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

endmodule

// File: hw/rtl/cdo_ctrl.sv
// ----------------------------------------------------------------------------
// cdo_ctrl
// Sequencer: accept, reduce year mod 400, check date, step days, emit.
// ----------------------------------------------------------------------------
`include "calendar_date_offset_macros.svh"

module cdo_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  cdo_pkg::sts_t sts,
  output cdo_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_REDUCE = 5'b00010,
    S_CHECK  = 5'b00100,
    S_STEP   = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (sts.ge_cycle) begin
          cmd.reduce = 1'b1;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.date_ok) begin
          cmd.mark_bad = 1'b1;
          state_nxt    = S_EMIT;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        priority if (sts.cnt_zero) begin
          state_nxt = S_EMIT;
        end else if (sts.at_end) begin
          cmd.sat   = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `CDO_ASSERT_IMP(a_step_live, cmd.step, !sts.cnt_zero && !sts.at_end, "step past end")
  `CDO_ASSERT_IMP(a_emit_free, cmd.emit, sts.out_free, "emit into busy output")
  `CDO_ASSERT_NXT(a_load_reduce, in_tvalid && in_tready, state_r == S_REDUCE, "no reduce")

endmodule

// File: hw/rtl/calendar_date_offset.sv
// ----------------------------------------------------------------------------
// calendar_date_offset
// Gregorian date plus signed day offset, stepped one day per cycle.
// ----------------------------------------------------------------------------
// A beat is accepted, its year is reduced modulo 400 by repeated subtraction
// (one subtract per cycle), the date is checked, the one-day stepper runs for
// min(|day_offset|, OFFSET_LIMIT) days (fewer when the result saturates, none
// for an invalid date), and the output register is loaded once it is free.
// An invalid date is echoed with status 1; a result past 0001-01-01 or
// 9999-12-31 saturates with status 2. The next beat is taken while a result
// waits in the output register.
module calendar_date_offset #(
  parameter int OFFSET_LIMIT = 1048575
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [13:0] start_year, [17:14] start_month, [22:18] start_day,
  // [43:23] day_offset, [47:44] zero
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [13:0] result_year, [17:14] result_month, [22:18] result_day,
  // [24:23] status, [31:25] zero
  output logic [31:0] out_tdata
);

  cdo_pkg::cmd_t cmd;
  cdo_pkg::sts_t sts;

  cdo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cdo_datapath #(
    .OFFSET_LIMIT (OFFSET_LIMIT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: bench/calendar_date_offset_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_offset_tb
// Self-checking bench for the Gregorian date offset block.
// ----------------------------------------------------------------------------
// Dates with signed day offsets go in on the input stream. Each accepted beat
// is run through a day-count predictor and queued. Each result beat is checked
// field by field against the oldest queued date. Directed cases cover the leap
// rules, month and year rollover, range saturation, invalid dates and both
// offset extremes. Random dates with mostly small offsets follow, under random
// idling, a long receiver hold-off and a drain pause.
// ----------------------------------------------------------------------------
module calendar_date_offset_tb;

  localparam int     DAY_SHIFT_MAX = 1048575;
  localparam longint DAYS_PER_400Y = 146097;
  localparam longint DAYS_PER_100Y = 36524;
  localparam longint DAYS_PER_4Y   = 1461;
  localparam longint DAYS_PER_YEAR = 365;
  localparam int     IDLE_PCT      = 28;
  localparam int     TAIL_CYCLES   = 60;

  typedef struct packed {
    logic [cdo_pkg::YEAR_W-1:0]  year;
    logic [cdo_pkg::MONTH_W-1:0] month;
    logic [cdo_pkg::DAY_W-1:0]   day;
    cdo_pkg::status_t            status;
  } cal_date_t;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [cdo_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [cdo_pkg::OUT_DATA_W-1:0] out_tdata;

  cal_date_t expected_dates[$];
  bit        gaps_on      = 1'b1;
  int        hold_len     = 0;
  int        hold_seq     = 0;
  int        hold_seen    = 0;
  int        hold_left    = 0;
  int        mismatches   = 0;
  int        dates_sent   = 0;
  int        invalid_sent = 0;
  int        sat_sent     = 0;
  int        results_seen = 0;

  calendar_date_offset #(
    .OFFSET_LIMIT(DAY_SHIFT_MAX)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #500_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---- predictor ----------------------------------------------------------

  function automatic bit leap_year(input longint y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int unsigned month_length(input longint y, input longint m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // days since 0001-01-01
  function automatic longint day_number(input longint y, input longint m, input longint d);
    longint yy;
    longint n;
    yy = y - 1;
    n = yy * DAYS_PER_YEAR + yy / 4 - yy / 100 + yy / 400;
    for (longint k = 1; k < m; k++) n += month_length(y, k);
    return n + d - 1;
  endfunction

  function automatic cal_date_t predict_shifted_date(
      input logic [cdo_pkg::YEAR_W-1:0] y,
      input logic [cdo_pkg::MONTH_W-1:0] m,
      input logic [cdo_pkg::DAY_W-1:0] d,
      input logic signed [cdo_pkg::OFF_W-1:0] off);
    cal_date_t r;
    longint    shift;
    longint    n;
    longint    last;
    longint    rem;
    longint    q400;
    longint    q100;
    longint    q4;
    longint    q1;
    longint    yr;
    longint    mo;
    r.status = cdo_pkg::ST_OK;
    if (y < cdo_pkg::YEAR_MIN || y > cdo_pkg::YEAR_MAX || m < 1 || m > cdo_pkg::MONTHS ||
        d < 1 || d > month_length(y, m)) begin
      r.year   = y;
      r.month  = m;
      r.day    = d;
      r.status = cdo_pkg::ST_INVALID;
      return r;
    end
    shift = longint'(off);
    if (shift > DAY_SHIFT_MAX) shift = DAY_SHIFT_MAX;
    if (shift < -longint'(DAY_SHIFT_MAX)) shift = -longint'(DAY_SHIFT_MAX);
    last = day_number(cdo_pkg::YEAR_MAX, cdo_pkg::MONTHS, cdo_pkg::DEC_LEN);
    n = day_number(y, m, d) + shift;
    if (n < 0) begin
      n = 0;
      r.status = cdo_pkg::ST_SAT;
    end
    if (n > last) begin
      n = last;
      r.status = cdo_pkg::ST_SAT;
    end
    q400 = n / DAYS_PER_400Y;
    rem  = n % DAYS_PER_400Y;
    q100 = rem / DAYS_PER_100Y;
    if (q100 > 3) q100 = 3;
    rem -= q100 * DAYS_PER_100Y;
    q4  = rem / DAYS_PER_4Y;
    rem = rem % DAYS_PER_4Y;
    q1  = rem / DAYS_PER_YEAR;
    if (q1 > 3) q1 = 3;
    rem -= q1 * DAYS_PER_YEAR;
    yr = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
    mo = 1;
    while (mo < cdo_pkg::MONTHS && rem >= month_length(yr, mo)) begin
      rem -= month_length(yr, mo);
      mo++;
    end
    rem = rem + 1;
    r.year  = yr[cdo_pkg::YEAR_W-1:0];
    r.month = mo[cdo_pkg::MONTH_W-1:0];
    r.day   = rem[cdo_pkg::DAY_W-1:0];
    return r;
  endfunction

  // ---- receiver and checker -----------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !gaps_on || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic flag_mismatch(input string what, input string want, input string got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] mismatch on %s: expected %s, got %s", $time, what, want, got);
  endtask

  always @(posedge clk) begin : check_results
    cal_date_t got;
    cal_date_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.year   = out_tdata[13:0];
      got.month  = out_tdata[17:14];
      got.day    = out_tdata[22:18];
      got.status = cdo_pkg::status_t'(out_tdata[24:23]);
      results_seen++;
      if (expected_dates.size() == 0) begin
        flag_mismatch("result beat", "none pending",
                      $sformatf("%0d-%0d-%0d status %0d",
                                got.year, got.month, got.day, got.status));
      end else begin
        want = expected_dates.pop_front();
        if (got.year != want.year)
          flag_mismatch("year", $sformatf("%0d", want.year), $sformatf("%0d", got.year));
        if (got.month != want.month)
          flag_mismatch("month", $sformatf("%0d", want.month), $sformatf("%0d", got.month));
        if (got.day != want.day)
          flag_mismatch("day", $sformatf("%0d", want.day), $sformatf("%0d", got.day));
        if (got.status != want.status)
          flag_mismatch("status", $sformatf("%0d", want.status),
                        $sformatf("%0d", got.status));
      end
    end
  end

  // ---- sender -------------------------------------------------------------

  // in_tvalid stays high after the beat; callers drop it with idle_input
  task automatic send_date(input logic [cdo_pkg::YEAR_W-1:0] y,
                           input logic [cdo_pkg::MONTH_W-1:0] m,
                           input logic [cdo_pkg::DAY_W-1:0] d,
                           input logic signed [cdo_pkg::OFF_W-1:0] off);
    cal_date_t want;
    while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, off, d, m, y};
    do @(posedge clk); while (!in_tready);
    want = predict_shifted_date(y, m, d, off);
    expected_dates.push_back(want);
    dates_sent++;
    if (want.status == cdo_pkg::ST_INVALID) invalid_sent++;
    if (want.status == cdo_pkg::ST_SAT) sat_sent++;
  endtask

  task automatic idle_input;
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_results_drained;
    while (expected_dates.size() != 0) @(posedge clk);
  endtask

  function automatic int unsigned pick_edge_year;
    case ($urandom_range(0, 12))
      0:       return 1;
      1:       return 4;
      2:       return 100;
      3:       return 400;
      4:       return 1600;
      5:       return 1700;
      6:       return 1800;
      7:       return 1900;
      8:       return 2000;
      9:       return 2100;
      10:      return 2400;
      11:      return 9998;
      default: return 9999;
    endcase
  endfunction

  function automatic int random_offset;
    int unsigned tier;
    int          mag;
    tier = $urandom_range(0, 99);
    if (tier < 70)      mag = $urandom_range(0, 400);
    else if (tier < 90) mag = $urandom_range(0, 4000);
    else                mag = $urandom_range(0, 40000);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  task automatic random_date_beat;
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned len;
    m = $urandom_range(1, 12);
    if ($urandom_range(0, 99) < 30) y = pick_edge_year();
    else y = $urandom_range(1, 9999);
    len = month_length(y, m);
    d = ($urandom_range(0, 3) == 0) ? len : $urandom_range(1, len);
    if ($urandom_range(0, 99) < 12) begin
      case ($urandom_range(0, 4))
        0: y = 0;
        1: y = $urandom_range(10000, 16383);
        2: begin
          m = $urandom_range(0, 3);
          if (m != 0) m = m + 12;
        end
        3: d = 0;
        default: begin
          case ($urandom_range(0, 4))
            0:       m = 2;
            1:       m = 4;
            2:       m = 6;
            3:       m = 9;
            default: m = 11;
          endcase
          d = $urandom_range(month_length(y, m) + 1, 31);
        end
      endcase
    end
    send_date(y, m, d, random_offset());
  endtask

  // ---- tests --------------------------------------------------------------

  task automatic test_leap_rules;
    send_date(2024, 2, 28, 1);
    send_date(1900, 2, 28, 1);
    send_date(2000, 2, 28, 1);
    send_date(2000, 3, 1, -1);
    send_date(2100, 3, 1, -1);
    send_date(2400, 2, 29, 365);
    idle_input();
  endtask

  task automatic test_rollover;
    send_date(1999, 12, 31, 1);
    send_date(2001, 1, 1, -1);
    send_date(1, 1, 1, 0);
    send_date(2023, 1, 31, 29);
    idle_input();
  endtask

  task automatic test_range_saturation;
    send_date(9999, 12, 31, 0);
    send_date(9999, 12, 31, 1);
    send_date(1, 1, 1, -1);
    send_date(9998, 6, 30, 1000);
    idle_input();
  endtask

  task automatic test_invalid_dates;
    send_date(0, 6, 15, 10);
    send_date(16383, 15, 31, -1);
    send_date(2023, 0, 10, 5);
    send_date(2023, 13, 1, 5);
    send_date(2023, 4, 0, 5);
    send_date(2023, 4, 31, 5);
    send_date(2023, 2, 29, 5);
    send_date(1900, 2, 29, -1);
    send_date(2024, 6, 31, -1048576);
    idle_input();
  endtask

  // each of these steps about a million days
  task automatic test_offset_extremes;
    send_date(5000, 6, 15, 1048575);
    send_date(5000, 6, 15, -1048576);
    idle_input();
  endtask

  task automatic test_output_backpressure;
    gaps_on = 1'b0;
    hold_len = 400;
    hold_seq++;
    repeat (8) send_date($urandom_range(1, 9999), $urandom_range(1, 12),
                         $urandom_range(1, 28), $urandom_range(0, 20));
    idle_input();
    wait_results_drained();
    gaps_on = 1'b1;
  endtask

  task automatic test_drain_pause;
    repeat (4) random_date_beat();
    idle_input();
    wait_results_drained();
    repeat (4) random_date_beat();
    idle_input();
  endtask

  task automatic test_random_dates(input int count);
    repeat (count) random_date_beat();
    idle_input();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_leap_rules();
    test_rollover();
    test_range_saturation();
    test_invalid_dates();
    test_offset_extremes();
    test_output_backpressure();
    test_drain_pause();
    test_random_dates(45);
    gaps_on = 1'b0;
    test_random_dates(25);
    gaps_on = 1'b1;
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d dates: %0d invalid, %0d saturated, leap and rollover edges",
             dates_sent, invalid_sent, sat_sent);
    $display("checked %0d result beats, %0d field mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
